@@ rtl/jsu_pkg.sv @@
// Shared types, codes and decode functions for the JSON string unescaper.
package jsu_pkg;

    localparam int QueueDepth = 4;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STR     = 3'd1,
        MODE_ESC     = 3'd2,
        MODE_HEX1    = 3'd3,
        MODE_WANT_BS = 3'd4,
        MODE_WANT_U  = 3'd5,
        MODE_HEX2    = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_NOQUOTE = 3'd1,
        ERR_UNTERM  = 3'd2,
        ERR_ENDESC  = 3'd3,
        ERR_BADESC  = 3'd4,
        ERR_BADHEX  = 3'd5,
        ERR_SURR    = 3'd6
    } t_err;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    // One queue entry: all words caused by one input word.
    typedef struct packed {
        t_kind            kind;
        t_err             err;
        logic [1:0]       last_idx;   // number of words minus one
        logic [3:0][7:0]  bytes;
    } t_grp;

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    // {valid, decoded byte} for single-character escapes
    function automatic logic [8:0] esc_val(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic t_grp utf8_grp(input logic [20:0] cp);
        t_grp g;
        g.kind  = KIND_DATA;
        g.err   = ERR_NONE;
        g.bytes = '0;
        if (cp[20:7] == '0) begin
            g.last_idx = 2'd0;
            g.bytes[0] = {1'b0, cp[6:0]};
        end else if (cp[20:11] == '0) begin
            g.last_idx = 2'd1;
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp[20:16] == '0) begin
            g.last_idx = 2'd2;
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            g.last_idx = 2'd3;
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

endpackage

@@ rtl/jsu_front.sv @@
// Front end: per-byte decode state machine, builds at most one result group per input word.
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_op,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output jsu_pkg::t_grp o_grp
);
    import jsu_pkg::*;

    t_mode       r_mode, n_mode;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_hs, n_hs;

    logic        fault;
    t_err        fcode;
    logic        emit;
    t_grp        grp;
    logic [4:0]  hv;
    logic [8:0]  ev;
    logic [15:0] acc_nx;
    logic [20:0] cp;

    assign hv     = hex_val(i_byte);
    assign ev     = esc_val(i_byte);
    assign acc_nx = {r_acc[11:0], hv[3:0]};
    assign cp     = (r_mode == MODE_HEX2)
                  ? {({1'b0, r_hs} + 11'd64), acc_nx[9:0]}
                  : {5'd0, acc_nx};

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_hs   = r_hs;
        fault  = 1'b0;
        fcode  = ERR_NONE;
        emit   = 1'b0;
        grp    = '{kind: KIND_DATA, err: ERR_NONE, last_idx: 2'd0, bytes: '0};

        unique case (r_mode) inside
            MODE_STR, MODE_ESC, MODE_HEX1, MODE_WANT_BS, MODE_WANT_U, MODE_HEX2: begin
                if (i_op) begin
                    fault = 1'b1;
                    if (r_mode == MODE_STR) fcode = ERR_UNTERM;
                    else if (r_mode == MODE_WANT_BS || r_mode == MODE_WANT_U) fcode = ERR_SURR;
                    else fcode = ERR_ENDESC;
                end else if (r_mode == MODE_STR) begin
                    if (i_byte == CH_QUOTE) begin
                        n_mode   = MODE_IDLE;
                        n_acc    = '0;
                        n_cnt    = '0;
                        n_hs     = '0;
                        emit     = 1'b1;
                        grp.kind = KIND_CLOSE;
                    end else if (i_byte == CH_BSL) begin
                        n_mode = MODE_ESC;
                    end else begin
                        emit         = 1'b1;
                        grp.bytes[0] = i_byte;
                    end
                end else if (r_mode == MODE_ESC) begin
                    if (i_byte == CH_U) begin
                        n_mode = MODE_HEX1;
                        n_acc  = '0;
                        n_cnt  = '0;
                    end else if (ev[8]) begin
                        n_mode       = MODE_STR;
                        emit         = 1'b1;
                        grp.bytes[0] = ev[7:0];
                    end else begin
                        fault = 1'b1;
                        fcode = ERR_BADESC;
                    end
                end else if (r_mode == MODE_WANT_BS) begin
                    if (i_byte == CH_BSL) n_mode = MODE_WANT_U;
                    else begin
                        fault = 1'b1;
                        fcode = ERR_SURR;
                    end
                end else if (r_mode == MODE_WANT_U) begin
                    if (i_byte == CH_U) begin
                        n_mode = MODE_HEX2;
                        n_acc  = '0;
                        n_cnt  = '0;
                    end else begin
                        fault = 1'b1;
                        fcode = ERR_SURR;
                    end
                end else begin
                    // hex group, first or second
                    if (!hv[4]) begin
                        fault = 1'b1;
                        fcode = ERR_BADHEX;
                    end else if (r_cnt != 2'd3) begin
                        n_acc = acc_nx;
                        n_cnt = r_cnt + 2'd1;
                    end else begin
                        n_acc = '0;
                        n_cnt = '0;
                        if (r_mode == MODE_HEX1 && acc_nx[15:10] == 6'b110110) begin
                            n_hs   = acc_nx[9:0];
                            n_mode = MODE_WANT_BS;
                        end else if (r_mode == MODE_HEX2 && acc_nx[15:10] != 6'b110111) begin
                            fault = 1'b1;
                            fcode = ERR_SURR;
                        end else begin
                            n_hs   = '0;
                            n_mode = MODE_STR;
                            emit   = 1'b1;
                            grp    = utf8_grp(cp);
                        end
                    end
                end
            end
            default: begin
                // idle, and the unused mode code
                if (i_op || i_byte != CH_QUOTE) begin
                    fault = 1'b1;
                    fcode = ERR_NOQUOTE;
                end else begin
                    n_mode = MODE_STR;
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_hs   = '0;
                end
            end
        endcase

        if (fault) begin
            n_mode = MODE_IDLE;
            n_acc  = '0;
            n_cnt  = '0;
            n_hs   = '0;
            emit   = 1'b1;
            grp    = '{kind: KIND_ERROR, err: fcode, last_idx: 2'd0, bytes: '0};
        end
    end

    assign o_push = i_accept && emit;
    assign o_grp  = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_hs   <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_hs   <= n_hs;
        end
    end

endmodule

@@ rtl/jsu_fifo.sv @@
// Short queue of result groups between front and back.
module jsu_fifo #(
    parameter int QDEPTH = jsu_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_grp i_grp,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output jsu_pkg::t_grp o_grp
);
    import jsu_pkg::*;

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    t_grp           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_grp   = r_mem[r_rd];

    function automatic logic [QAW-1:0] wrap_inc(input logic [QAW-1:0] p);
        return (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_grp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= wrap_inc(r_wr);
            if (do_pop)  r_rd <= wrap_inc(r_rd);
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

@@ rtl/jsu_back.sv @@
// Back end: unpacks result groups into output words, one word per cycle unless i_ready holds the output back.
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  jsu_pkg::t_grp i_grp,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_kind,
    output logic [7:0]    o_byte,
    output logic [2:0]    o_err,
    output logic          o_last
);
    import jsu_pkg::*;

    t_grp       r_grp;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_byte;
    logic [2:0] r_err;
    logic       r_last;
    logic       adv, fin;

    assign adv   = !r_valid || i_ready;
    assign fin   = r_busy && adv && (r_idx == r_grp.last_idx);
    assign o_pop = (!r_busy || fin) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (adv) r_valid <= r_busy;
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (fin) begin
                r_busy <= 1'b0;
            end else if (r_busy && adv) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_grp <= i_grp;
        if (adv && r_busy) begin
            r_kind <= r_grp.kind;
            r_byte <= r_grp.bytes[r_idx];
            r_err  <= r_grp.err;
            r_last <= (r_idx == r_grp.last_idx);
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_byte  = r_byte;
    assign o_err   = r_err;
    assign o_last  = r_last;

endmodule

@@ rtl/json_string_unescape_utf8_unit.sv @@
// Top level of the JSON string unescaper with UTF-8 output.
// Feeds a quoted JSON string one byte per word and returns the decoded bytes, then one
// close or error word. Simple escapes and \uXXXX (surrogate pairs joined) are decoded;
// code points leave as 1 to 4 UTF-8 bytes, raw bytes pass unchanged. After a close or an
// error the unit waits for a new opening quote. The input side takes one word per cycle
// whenever the result queue (QDEPTH groups) has room; a word yields 0 to 4 output words,
// and the output side sends one word per cycle while m_axis_tready is high and words are
// pending. A word that expands to several bytes comes after at least five words that yield
// none. The input stalls only while the queue is full. An accepted input word reaches the
// output through the queue, the back end's group register and its output register.
// The last output word caused by an input word carries tlast. No clearing pass after reset.
module json_string_unescape_utf8_unit #(
    parameter int QDEPTH = jsu_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] op: 0 text byte, 1 end of input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, [15:11] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind: data, close, error
    output logic        m_axis_tlast    // last word caused by one input word
);
    import jsu_pkg::*;

    logic       accept, push, pop, full, empty;
    t_grp       grp_in, grp_out;
    logic [1:0] kind;
    logic [7:0] obyte;
    logic [2:0] err;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (s_axis_tuser),
        .i_byte   (s_axis_tdata),
        .o_push   (push),
        .o_grp    (grp_in)
    );

    jsu_fifo #(.QDEPTH(QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (grp_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_grp   (grp_out)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_grp   (grp_out),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (kind),
        .o_byte  (obyte),
        .o_err   (err),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, err, obyte};
    assign m_axis_tuser = kind;

endmodule

@@ verif/tb_json_string_unescape_utf8_unit.sv @@
// Self-checking testbench for the JSON string unescaper: text words in, predicted UTF-8 words out.
import jsu_pkg::*;

typedef struct {
    t_kind      kind;
    logic [7:0] out_byte;
    t_err       err;
    logic       last;
} unescape_word_t;

// Tracks the unescaper state, predicts the words each text word causes and checks the output.
class unescape_scoreboard;
    t_mode          mode;
    logic [15:0]    hex_acc;
    logic [1:0]     digit_cnt;
    logic [9:0]     high_held;
    unescape_word_t burst[4];
    int             burst_len;
    unescape_word_t decoded_queue[$];
    int             errors;

    function new();
        go_idle();
        errors = 0;
    endfunction

    function void go_idle();
        mode      = MODE_IDLE;
        hex_acc   = 16'd0;
        digit_cnt = 2'd0;
        high_held = 10'd0;
    endfunction

    function void add(t_kind k, logic [7:0] b, t_err e);
        burst[burst_len].kind     = k;
        burst[burst_len].out_byte = b;
        burst[burst_len].err      = e;
        burst[burst_len].last     = 1'b0;
        burst_len++;
    endfunction

    function void fail(t_err e);
        go_idle();
        add(KIND_ERROR, 8'h00, e);
    endfunction

    function int pending();
        return decoded_queue.size();
    endfunction

    // Accepted input word: advance the decoder and queue what it produces.
    function void note_word(logic op, logic [7:0] c);
        logic [7:0]  esc;
        logic        esc_ok;
        logic [7:0]  diff;
        logic [3:0]  nib;
        logic        nib_ok;
        logic [15:0] v;
        logic [20:0] cp;
        burst_len = 0;
        if (mode == MODE_IDLE) begin
            if (op || c != CH_QUOTE) fail(ERR_NOQUOTE);
            else begin
                go_idle();
                mode = MODE_STR;
            end
        end else if (op) begin
            case (mode)
                MODE_STR:                  fail(ERR_UNTERM);
                MODE_WANT_BS, MODE_WANT_U: fail(ERR_SURR);
                default:                   fail(ERR_ENDESC);
            endcase
        end else begin
            case (mode)
                MODE_STR: begin
                    if (c == CH_QUOTE) begin
                        go_idle();
                        add(KIND_CLOSE, 8'h00, ERR_NONE);
                    end else if (c == CH_BSL) begin
                        mode = MODE_ESC;
                    end else begin
                        add(KIND_DATA, c, ERR_NONE);
                    end
                end
                MODE_ESC: begin
                    esc    = c;
                    esc_ok = 1'b1;
                    case (c)
                        CH_QUOTE, CH_BSL, "/": esc = c;
                        "b":     esc = 8'h08;
                        "f":     esc = 8'h0C;
                        "n":     esc = 8'h0A;
                        "r":     esc = 8'h0D;
                        "t":     esc = 8'h09;
                        default: esc_ok = 1'b0;
                    endcase
                    if (c == CH_U) begin
                        mode      = MODE_HEX1;
                        hex_acc   = 16'd0;
                        digit_cnt = 2'd0;
                    end else if (!esc_ok) begin
                        fail(ERR_BADESC);
                    end else begin
                        mode = MODE_STR;
                        add(KIND_DATA, esc, ERR_NONE);
                    end
                end
                MODE_WANT_BS: begin
                    if (c != CH_BSL) fail(ERR_SURR);
                    else mode = MODE_WANT_U;
                end
                MODE_WANT_U: begin
                    if (c != CH_U) fail(ERR_SURR);
                    else begin
                        mode      = MODE_HEX2;
                        hex_acc   = 16'd0;
                        digit_cnt = 2'd0;
                    end
                end
                default: begin
                    // either hex group
                    nib_ok = 1'b1;
                    nib    = 4'd0;
                    if (c >= "0" && c <= "9") diff = c - "0";
                    else if (c >= "a" && c <= "f") diff = c - "a" + 8'd10;
                    else if (c >= "A" && c <= "F") diff = c - "A" + 8'd10;
                    else begin
                        diff   = 8'd0;
                        nib_ok = 1'b0;
                    end
                    nib = diff[3:0];
                    if (!nib_ok) begin
                        fail(ERR_BADHEX);
                    end else begin
                        hex_acc = {hex_acc[11:0], nib};
                        if (digit_cnt != 2'd3) begin
                            digit_cnt = digit_cnt + 2'd1;
                        end else begin
                            digit_cnt = 2'd0;
                            v         = hex_acc;
                            hex_acc   = 16'd0;
                            if (mode == MODE_HEX1 && v >= 16'hD800 && v <= 16'hDBFF) begin
                                // low ten bits are the offset from D800
                                high_held = v[9:0];
                                mode      = MODE_WANT_BS;
                            end else if (mode == MODE_HEX2 && (v < 16'hDC00 || v > 16'hDFFF)) begin
                                fail(ERR_SURR);
                            end else begin
                                if (mode == MODE_HEX1) cp = {5'd0, v};
                                else cp = 21'h10000 + {1'b0, high_held, v[9:0]};
                                high_held = 10'd0;
                                mode      = MODE_STR;
                                if (cp < 21'h80) begin
                                    add(KIND_DATA, cp[7:0], ERR_NONE);
                                end else if (cp < 21'h800) begin
                                    add(KIND_DATA, 8'hC0 | {3'd0, cp[10:6]}, ERR_NONE);
                                    add(KIND_DATA, 8'h80 | {2'd0, cp[5:0]}, ERR_NONE);
                                end else if (cp < 21'h10000) begin
                                    add(KIND_DATA, 8'hE0 | {4'd0, cp[15:12]}, ERR_NONE);
                                    add(KIND_DATA, 8'h80 | {2'd0, cp[11:6]}, ERR_NONE);
                                    add(KIND_DATA, 8'h80 | {2'd0, cp[5:0]}, ERR_NONE);
                                end else begin
                                    add(KIND_DATA, 8'hF0 | {5'd0, cp[20:18]}, ERR_NONE);
                                    add(KIND_DATA, 8'h80 | {2'd0, cp[17:12]}, ERR_NONE);
                                    add(KIND_DATA, 8'h80 | {2'd0, cp[11:6]}, ERR_NONE);
                                    add(KIND_DATA, 8'h80 | {2'd0, cp[5:0]}, ERR_NONE);
                                end
                            end
                        end
                    end
                end
            endcase
        end
        for (int i = 0; i < burst_len; i++) begin
            burst[i].last = (i == burst_len - 1);
            decoded_queue = {decoded_queue, burst[i]};
        end
    endfunction

    // Accepted output word: compare with the oldest expected word.
    function void check_word(logic [1:0] kind, logic [15:0] data, logic last);
        unescape_word_t exp_w;
        if (decoded_queue.size() == 0) begin
            $error("output word with nothing pending: kind %0d data %h", kind, data);
            errors++;
            return;
        end
        exp_w = decoded_queue.pop_front();
        if (kind !== exp_w.kind) begin
            $error("kind: expected %0d, actual %0d", exp_w.kind, kind);
            errors++;
        end
        if (data[7:0] !== exp_w.out_byte) begin
            $error("out_byte: expected %h, actual %h", exp_w.out_byte, data[7:0]);
            errors++;
        end
        if (data[10:8] !== exp_w.err) begin
            $error("error_code: expected %0d, actual %0d", exp_w.err, data[10:8]);
            errors++;
        end
        if (data[15:11] !== 5'd0) begin
            $error("tdata pad: expected 0, actual %h", data[15:11]);
            errors++;
        end
        if (last !== exp_w.last) begin
            $error("last: expected %0d, actual %0d", exp_w.last, last);
            errors++;
        end
    endfunction
endclass

module tb_json_string_unescape_utf8_unit;

    localparam int StallLimit  = 1000;
    localparam int DrainCycles = 20;
    localparam int RandomWords = 460;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic        s_axis_tuser = 1'b0;    // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] out_byte, [10:8] error_code, [15:11] zero
    logic [1:0]  m_axis_tuser;           // [1:0] kind
    logic        m_axis_tlast;

    unescape_scoreboard sb;
    int   words_sent = 0;
    int   stall_cycles = 0;
    logic no_gaps = 1'b0;

    json_string_unescape_utf8_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // output backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 37);
    end

    // handshake monitor; both sides sampled before this edge's updates
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tuser, m_axis_tdata, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial begin
        wait (stall_cycles >= StallLimit);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // value in [lo, hi], with the bounds themselves picked often
    function automatic logic [15:0] pick_value(input logic [15:0] lo, input logic [15:0] hi);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return "0" + {4'd0, n};
        if ($urandom_range(0, 1) == 0) return "a" - 8'd10 + {4'd0, n};
        return "A" - 8'd10 + {4'd0, n};
    endfunction

    task automatic send_word(input logic op, input logic [7:0] b);
        while (!no_gaps && $urandom_range(0, 99) < 37) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    // leading 'count' hex digits of v
    task automatic send_hex_digits(input logic [15:0] v, input int count);
        logic [15:0] w;
        for (int i = 0; i < count; i++) begin
            w = v >> (12 - 4 * i);
            send_word(1'b0, hex_char(w[3:0]));
        end
    endtask

    task automatic send_u_escape(input logic [15:0] v);
        send_word(1'b0, CH_BSL);
        send_word(1'b0, CH_U);
        send_hex_digits(v, 4);
    endtask

    task automatic send_non_hex();
        logic [7:0] c;
        do c = rnd_byte();
        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
        send_word(1'b0, c);
    endtask

    // One piece of string body. Broken pieces leave the decoder idle again.
    task automatic send_token(output logic broken);
        int         sel;
        int         sub;
        logic [7:0] c;
        broken = 1'b0;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            do c = rnd_byte(); while (c == CH_QUOTE || c == CH_BSL);
            send_word(1'b0, c);
        end else if (sel < 55) begin
            sub = $urandom_range(0, 7);
            case (sub)
                0:       c = CH_QUOTE;
                1:       c = CH_BSL;
                2:       c = "/";
                3:       c = "b";
                4:       c = "f";
                5:       c = "n";
                6:       c = "r";
                default: c = "t";
            endcase
            send_word(1'b0, CH_BSL);
            send_word(1'b0, c);
        end else if (sel < 88) begin
            sub = $urandom_range(0, 4);
            case (sub)
                0: send_u_escape(pick_value(16'h0000, 16'h007F));
                1: send_u_escape(pick_value(16'h0080, 16'h07FF));
                2: begin
                    if ($urandom_range(0, 1) == 0) send_u_escape(pick_value(16'h0800, 16'hD7FF));
                    else send_u_escape(pick_value(16'hE000, 16'hFFFF));
                end
                3: send_u_escape(pick_value(16'hDC00, 16'hDFFF));   // lone low surrogate
                default: begin
                    send_u_escape(pick_value(16'hD800, 16'hDBFF));
                    send_u_escape(pick_value(16'hDC00, 16'hDFFF));
                end
            endcase
        end else begin
            broken = 1'b1;
            sub = $urandom_range(0, 6);
            case (sub)
                0: begin
                    do c = rnd_byte();
                    while (c == CH_QUOTE || c == CH_BSL || c == "/" || c == "b" || c == "f"
                           || c == "n" || c == "r" || c == "t" || c == CH_U);
                    send_word(1'b0, CH_BSL);
                    send_word(1'b0, c);
                end
                1: begin
                    send_word(1'b0, CH_BSL);
                    send_word(1'b0, CH_U);
                    send_hex_digits(16'($urandom), $urandom_range(0, 3));
                    send_non_hex();
                end
                2: begin
                    send_u_escape(pick_value(16'hD800, 16'hDBFF));
                    do c = rnd_byte(); while (c == CH_BSL);
                    send_word(1'b0, c);
                end
                3: begin
                    send_u_escape(pick_value(16'hD800, 16'hDBFF));
                    send_word(1'b0, CH_BSL);
                    do c = rnd_byte(); while (c == CH_U);
                    send_word(1'b0, c);
                end
                4: begin
                    // second group is not a low surrogate
                    send_u_escape(pick_value(16'hD800, 16'hDBFF));
                    if ($urandom_range(0, 1) == 0) send_u_escape(pick_value(16'h0000, 16'hDBFF));
                    else send_u_escape(pick_value(16'hE000, 16'hFFFF));
                end
                5: begin
                    send_u_escape(pick_value(16'hD800, 16'hDBFF));
                    send_word(1'b0, CH_BSL);
                    send_word(1'b0, CH_U);
                    send_hex_digits(16'($urandom), $urandom_range(0, 3));
                    send_non_hex();
                end
                default: begin
                    // input ends somewhere inside an escape
                    sub = $urandom_range(0, 4);
                    if (sub >= 2) send_u_escape(pick_value(16'hD800, 16'hDBFF));
                    if (sub != 2) send_word(1'b0, CH_BSL);
                    if (sub == 1 || sub == 4) begin
                        send_word(1'b0, CH_U);
                        send_hex_digits(16'($urandom), $urandom_range(0, 3));
                    end
                    send_word(1'b1, rnd_byte());
                end
            endcase
        end
    endtask

    task automatic send_random_string();
        int         sel;
        int         ntok;
        logic       broken;
        logic [7:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
            send_word(1'b1, rnd_byte());
        end else begin
            if (sel < 10) begin
                do c = rnd_byte(); while (c == CH_QUOTE);
                send_word(1'b0, c);
            end
            send_word(1'b0, CH_QUOTE);
            ntok   = $urandom_range(0, 6);
            broken = 1'b0;
            for (int k = 0; k < ntok && !broken; k++) send_token(broken);
            if (!broken) begin
                if ($urandom_range(0, 9) == 0) send_word(1'b1, rnd_byte());
                else send_word(1'b0, CH_QUOTE);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle: stray byte, then end of input
        send_word(1'b0, "x");
        send_word(1'b1, 8'hFF);
        // byte extremes, a simple escape, top of the BMP, then input ends in the body
        send_word(1'b0, CH_QUOTE);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, CH_BSL);
        send_word(1'b0, "n");
        send_u_escape(16'hFFFF);
        send_word(1'b1, 8'h00);
        // bad escape character
        send_word(1'b0, CH_QUOTE);
        send_word(1'b0, CH_BSL);
        send_word(1'b0, "q");
        // input ends right after a backslash
        send_word(1'b0, CH_QUOTE);
        send_word(1'b0, CH_BSL);
        send_word(1'b1, 8'h00);

        while (words_sent < RandomWords) begin
            no_gaps <= (words_sent >= 200 && words_sent < 300);
            send_random_string();
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
